// ===== rtl/per_port_output_queue_ecn_macros.svh =====
`ifndef PER_PORT_OUTPUT_QUEUE_ECN_MACROS_SVH
`define PER_PORT_OUTPUT_QUEUE_ECN_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ppq_pkg.sv =====
package ppq_pkg;

	localparam int NUM_PORTS   = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_WIDTH   = 16;
	localparam int ADDR_WIDTH  = 8;

	localparam int OP_W     = 2;
	localparam int PORT_FW  = 3;
	localparam int STATUS_W = 2;
	localparam int LIMIT_W  = 5;

	localparam int PORT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W     = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;
	localparam int MEM_DEPTH = NUM_PORTS * QUEUE_DEPTH;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// floor(x/3) == (x*11) >> 5 for every 5-bit x
	localparam int ECN_RECIP = 11;
	localparam int ECN_SHIFT = 5;
	localparam int THR_PW    = LIMIT_W + 4;

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_AW    = 1;
	localparam int CMDQ_CW    = 2;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IW  = 1;

	localparam logic [REG_IW-1:0] REG_ROUTER_ADDRESS = 1'b0;
	localparam logic [REG_IW-1:0] REG_QUEUE_LIMIT    = 1'b1;

	localparam logic [ADDR_WIDTH-1:0] ROUTER_ADDRESS_RESET = '0;
	localparam logic [LIMIT_W-1:0]    QUEUE_LIMIT_RESET    = 5'd16;

	localparam logic [OP_W-1:0] OP_LOCAL_SEND   = 2'd0;
	localparam logic [OP_W-1:0] OP_LINK_ARRIVAL = 2'd1;
	localparam logic [OP_W-1:0] OP_TX_DONE      = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_ABSORBED = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd3;

	typedef enum logic [2:0] {
		CMD_ENQUEUE,
		CMD_DROP,
		CMD_ABSORB,
		CMD_DONE,
		CMD_DONE_NOP
	} cmd_kind_t;

	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [ADDR_WIDTH-1:0] dest_address;
		logic [PORT_FW-1:0]    next_hop;
		logic [TAG_WIDTH-1:0]  packet_tag;
		logic                  ecn_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic                 fwd_valid;
		logic [PORT_FW-1:0]   fwd_port;
		logic [TAG_WIDTH-1:0] fwd_tag;
		logic                 fwd_ecn;
	} rsp_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [PORT_FW-1:0]   port;
		logic [TAG_WIDTH-1:0] tag;
		logic                 ecn;
	} cmd_t;

	typedef struct packed {
		logic [TAG_WIDTH-1:0] tag;
		logic                 mark;
	} slot_t;

endpackage

// ===== rtl/per_port_output_queue_ecn.sv =====
// An accepted transfer is registered in the command queue, then its result in the result
// register. One item per cycle while rsp_ready does not stall; each event is a single
// read-modify-write of its port's head/tail/occupancy/busy registers, at most one slot
// memory write and one registered read. Reset: arst_n clears port pointers, occupancy,
// busy flags, the command queue and rsp_valid; router_address goes to 0 and queue_limit
// to 16. Slot memory is not cleared and the block takes items right after reset.
`include "per_port_output_queue_ecn_macros.svh"

module per_port_output_queue_ecn (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ppq_pkg::req_t                 req_data,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ppq_pkg::rsp_t                 rsp_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppq_pkg::PADDR_W-1:0]   paddr,
	input  logic [ppq_pkg::PDATA_W-1:0]   pwdata,
	output logic [ppq_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [ppq_pkg::ADDR_WIDTH-1:0] router_address_q;
	logic [ppq_pkg::LIMIT_W-1:0]    queue_limit_q;
	logic [ppq_pkg::REG_IW-1:0]     reg_index;
	logic                           cfg_write;

	logic          push_valid;
	logic          push_ready;
	ppq_pkg::cmd_t push_data;
	logic          cmd_valid;
	logic          cmd_ready;
	ppq_pkg::cmd_t cmd_data;

	assign pready    = 1'b1;
	assign reg_index = paddr[2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_address_q <= ppq_pkg::ROUTER_ADDRESS_RESET;
			queue_limit_q    <= ppq_pkg::QUEUE_LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (reg_index)
				ppq_pkg::REG_ROUTER_ADDRESS:
					router_address_q <= pwdata[ppq_pkg::ADDR_WIDTH-1:0];
				ppq_pkg::REG_QUEUE_LIMIT:
					queue_limit_q <= pwdata[ppq_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			ppq_pkg::REG_ROUTER_ADDRESS: prdata = ppq_pkg::PDATA_W'(router_address_q);
			ppq_pkg::REG_QUEUE_LIMIT:    prdata = ppq_pkg::PDATA_W'(queue_limit_q);
			default:                     prdata = '0;
		endcase
	end

	ppq_front u_front (
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req_data       (req_data),
		.router_address (router_address_q),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_data      (push_data)
	);

	ppq_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (cmd_valid),
		.pop_ready  (cmd_ready),
		.pop_data   (cmd_data)
	);

	ppq_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd_data    (cmd_data),
		.queue_limit (queue_limit_q),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp_data    (rsp_data)
	);

	`PPQ_ASSERT_NOW(a_no_fwd_on_drop_absorb, rsp_valid && (rsp_data.status == ppq_pkg::STATUS_DROPPED || rsp_data.status == ppq_pkg::STATUS_ABSORBED), !rsp_data.fwd_valid, "forward on a dropped or absorbed packet")
	`PPQ_ASSERT_NOW(a_idle_fwd_zero, rsp_valid && !rsp_data.fwd_valid, rsp_data.fwd_port == '0 && rsp_data.fwd_tag == '0 && !rsp_data.fwd_ecn, "forward fields not zero without a forward")
	`PPQ_ASSERT_NEXT(a_push_reaches_back, req_valid && req_ready, cmd_valid, "accepted transfer not queued for the back end")
	`PPQ_ASSERT_NEXT(a_limit_write, cfg_write && reg_index == ppq_pkg::REG_QUEUE_LIMIT, queue_limit_q == $past(pwdata[ppq_pkg::LIMIT_W-1:0]), "queue_limit write lost")

endmodule

// ===== rtl/ppq_front.sv =====
module ppq_front (
	input  logic                              req_valid,
	output logic                              req_ready,
	input  ppq_pkg::req_t                     req_data,
	input  logic [ppq_pkg::ADDR_WIDTH-1:0]    router_address,
	output logic                              push_valid,
	input  logic                              push_ready,
	output ppq_pkg::cmd_t                     push_data
);

	logic port_ok;

	assign port_ok = 32'(req_data.next_hop) < 32'(ppq_pkg::NUM_PORTS);

	always_comb begin
		push_data.port = req_data.next_hop;
		push_data.tag  = req_data.packet_tag;
		push_data.ecn  = req_data.ecn_in;
		// op three decodes as transmit-done
		if (req_data.op[1]) begin
			push_data.kind = port_ok ? ppq_pkg::CMD_DONE : ppq_pkg::CMD_DONE_NOP;
		end else if (req_data.op == ppq_pkg::OP_LINK_ARRIVAL &&
				req_data.dest_address == router_address) begin
			push_data.kind = ppq_pkg::CMD_ABSORB;
		end else if (!port_ok) begin
			push_data.kind = ppq_pkg::CMD_DROP;
		end else begin
			push_data.kind = ppq_pkg::CMD_ENQUEUE;
		end
	end

	assign push_valid = req_valid;
	assign req_ready  = push_ready;

endmodule

// ===== rtl/ppq_cmd_fifo.sv =====
module ppq_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  ppq_pkg::cmd_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output ppq_pkg::cmd_t pop_data
);

	ppq_pkg::cmd_t                  entry_q [ppq_pkg::CMDQ_DEPTH];
	logic [ppq_pkg::CMDQ_AW-1:0]    wr_ptr_q;
	logic [ppq_pkg::CMDQ_AW-1:0]    rd_ptr_q;
	logic [ppq_pkg::CMDQ_CW-1:0]    count_q;
	logic                           push;
	logic                           pop;

	assign push_ready = count_q != ppq_pkg::CMDQ_CW'(ppq_pkg::CMDQ_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

// ===== rtl/ppq_back.sv =====
module ppq_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  ppq_pkg::cmd_t                  cmd_data,
	input  logic [ppq_pkg::LIMIT_W-1:0]    queue_limit,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output ppq_pkg::rsp_t                  rsp_data
);

	function automatic logic [ppq_pkg::IDX_W-1:0] idx_next(
		input logic [ppq_pkg::IDX_W-1:0] i
	);
		return (32'(i) == ppq_pkg::QUEUE_DEPTH - 1) ? '0 : i + 1'b1;
	endfunction

	logic [ppq_pkg::IDX_W-1:0]  head_q [ppq_pkg::NUM_PORTS];
	logic [ppq_pkg::IDX_W-1:0]  tail_q [ppq_pkg::NUM_PORTS];
	logic [ppq_pkg::OCC_W-1:0]  occ_q  [ppq_pkg::NUM_PORTS];
	logic                       busy_q [ppq_pkg::NUM_PORTS];

	ppq_pkg::slot_t             mem [ppq_pkg::MEM_DEPTH];
	ppq_pkg::slot_t             rd_q;

	logic                           rsp_valid_q;
	logic [ppq_pkg::STATUS_W-1:0]   status_q;
	logic                           fwd_q;
	logic [ppq_pkg::PORT_FW-1:0]    port_q;
	logic                           byp_q;
	ppq_pkg::slot_t                 byp_slot_q;

	logic                           exec;
	logic [ppq_pkg::PORT_W-1:0]     p;
	logic [ppq_pkg::OCC_W-1:0]      occ;
	logic                           busy;
	logic [ppq_pkg::LIMIT_W-1:0]    lim;
	logic [ppq_pkg::THR_PW-1:0]     thr_prod;
	logic [ppq_pkg::LIMIT_W-1:0]    thr;
	logic                           full;
	logic                           over_thr;
	logic [ppq_pkg::STATUS_W-1:0]   status;
	logic                           enq;
	logic                           fwd;
	logic                           busy_next;
	logic                           bypass;
	ppq_pkg::slot_t                 wr_slot;
	logic [ppq_pkg::MEM_AW-1:0]     wr_addr;
	logic [ppq_pkg::MEM_AW-1:0]     rd_addr;

	assign cmd_ready = !rsp_valid_q || rsp_ready;
	assign exec      = cmd_valid && cmd_ready;

	assign p    = ppq_pkg::PORT_W'(cmd_data.port);
	assign occ  = occ_q[p];
	assign busy = busy_q[p];

	assign lim = (ppq_pkg::CMP_W'(queue_limit) > ppq_pkg::CMP_W'(ppq_pkg::QUEUE_DEPTH)) ?
		ppq_pkg::LIMIT_W'(ppq_pkg::QUEUE_DEPTH) : queue_limit;
	assign thr_prod = ppq_pkg::THR_PW'(lim) * ppq_pkg::THR_PW'(ppq_pkg::ECN_RECIP);
	assign thr      = ppq_pkg::LIMIT_W'(thr_prod >> ppq_pkg::ECN_SHIFT);
	assign full     = ppq_pkg::CMP_W'(occ) >= ppq_pkg::CMP_W'(lim);
	assign over_thr = ppq_pkg::CMP_W'(occ) >= ppq_pkg::CMP_W'(thr);

	always_comb begin
		status    = ppq_pkg::STATUS_DONE;
		enq       = 1'b0;
		fwd       = 1'b0;
		busy_next = busy;
		unique case (cmd_data.kind)
			ppq_pkg::CMD_ENQUEUE: begin
				if (full) begin
					status = ppq_pkg::STATUS_DROPPED;
				end else begin
					status = ppq_pkg::STATUS_ENQUEUED;
					enq    = 1'b1;
					fwd    = !busy;
				end
			end
			ppq_pkg::CMD_DROP:   status = ppq_pkg::STATUS_DROPPED;
			ppq_pkg::CMD_ABSORB: status = ppq_pkg::STATUS_ABSORBED;
			ppq_pkg::CMD_DONE: begin
				busy_next = 1'b0;
				fwd       = occ != '0;
			end
			ppq_pkg::CMD_DONE_NOP: status = ppq_pkg::STATUS_DONE;
			default: status = ppq_pkg::STATUS_DONE;
		endcase
		if (fwd) busy_next = 1'b1;
	end

	// empty queue: the slot written now is the head being forwarded
	assign bypass = enq && fwd && (occ == '0);

	assign wr_slot.tag  = cmd_data.tag;
	assign wr_slot.mark = cmd_data.ecn || over_thr;
	assign wr_addr = ppq_pkg::MEM_AW'(p) * ppq_pkg::MEM_AW'(ppq_pkg::QUEUE_DEPTH) +
		ppq_pkg::MEM_AW'(tail_q[p]);
	assign rd_addr = ppq_pkg::MEM_AW'(p) * ppq_pkg::MEM_AW'(ppq_pkg::QUEUE_DEPTH) +
		ppq_pkg::MEM_AW'(head_q[p]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ppq_pkg::NUM_PORTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				occ_q[i]  <= '0;
				busy_q[i] <= 1'b0;
			end
		end else if (exec) begin
			if (enq) tail_q[p] <= idx_next(tail_q[p]);
			if (fwd) head_q[p] <= idx_next(head_q[p]);
			if (enq && !fwd) occ_q[p] <= occ + 1'b1;
			else if (fwd && !enq) occ_q[p] <= occ - 1'b1;
			busy_q[p] <= busy_next;
		end
	end

	always_ff @(posedge clk) begin
		if (exec && enq) mem[wr_addr] <= wr_slot;
		if (exec && fwd) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			status_q   <= status;
			fwd_q      <= fwd;
			port_q     <= cmd_data.port;
			byp_q      <= bypass;
			byp_slot_q <= wr_slot;
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign rsp_data.status    = status_q;
	assign rsp_data.fwd_valid = fwd_q;
	assign rsp_data.fwd_port  = fwd_q ? port_q : '0;
	assign rsp_data.fwd_tag   = !fwd_q ? '0 : (byp_q ? byp_slot_q.tag : rd_q.tag);
	assign rsp_data.fwd_ecn   = fwd_q && (byp_q ? byp_slot_q.mark : rd_q.mark);

endmodule
